### rtl/rse_pkg.sv
// Shared types and constants of the RISC subset execute unit.
// Holds instruction encodings, status codes and the packed result layout.
// No dependencies.
package rse_pkg;

	// Primary opcodes, instruction bits 31..26.
	localparam logic [5:0] OP_ST     = 6'h09;
	localparam logic [5:0] OP_AND    = 6'h10;
	localparam logic [5:0] OP_AND_U  = 6'h11;
	localparam logic [5:0] OP_XOR    = 6'h14;
	localparam logic [5:0] OP_XOR_U  = 6'h15;
	localparam logic [5:0] OP_OR     = 6'h16;
	localparam logic [5:0] OP_OR_U   = 6'h17;
	localparam logic [5:0] OP_CTRL   = 6'h20;
	localparam logic [5:0] OP_BR     = 6'h30;
	localparam logic [5:0] OP_BR_N   = 6'h31;
	localparam logic [5:0] OP_BSR    = 6'h32;
	localparam logic [5:0] OP_BSR_N  = 6'h33;
	localparam logic [5:0] OP_BB0    = 6'h34;
	localparam logic [5:0] OP_BB0_N  = 6'h35;
	localparam logic [5:0] OP_BB1    = 6'h36;
	localparam logic [5:0] OP_BB1_N  = 6'h37;
	localparam logic [5:0] OP_REGOPS = 6'h3d;

	// Sub-opcodes of the register-form group, instruction bits 15..8.
	localparam logic [7:0] SUB_AND   = 8'h40;
	localparam logic [7:0] SUB_XOR   = 8'h50;
	localparam logic [7:0] SUB_OR    = 8'h58;
	localparam logic [7:0] SUB_JMP   = 8'hc0;
	localparam logic [7:0] SUB_JMP_N = 8'hc4;

	// Control register access patterns.
	localparam logic [31:0] LDCR_MASK  = 32'h001ff81f;
	localparam logic [31:0] LDCR_MATCH = 32'h00004000;
	localparam logic [31:0] STCR_MASK  = 32'h03e0f800;
	localparam logic [31:0] STCR_MATCH = 32'h00008000;

	localparam logic [4:0] LINK_REG = 5'd1;
	localparam int unsigned NUM_REGS = 32;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ILLEGAL   = 2'd1,
		ST_CTRL_REG  = 2'd2,
		ST_SLOT_BRAN = 2'd3
	} status_t;

	// Result word, last field in the lowest bits, padded to 144 bits.
	typedef struct packed {
		logic [6:0]  pad;
		status_t     status;
		logic [31:0] store_value;
		logic [31:0] store_address;
		logic        store_valid;
		logic [31:0] writeback_value;
		logic [4:0]  writeback_index;
		logic        writeback_valid;
		logic [31:0] next_fetch_address;
	} result_t;

	// Register write captured for forwarding into the following read.
	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [31:0] val;
	} fwd_t;

endpackage

### rtl/risc_subset_execute_unit.sv
// Top level of the RISC subset execute unit: decode, register file memory,
// branch and delay-slot control, and the result output register.
// Depends on rse_pkg.

// The unit retires one instruction per clock cycle while the output side is not
// stalled: a request on s_tdata is an instruction fetched at the address the
// previous result reported in next_fetch_address (or at reset_address after a
// reset_address write, or at zero after reset). Every request produces exactly
// one result; the request is held in the execute stage, its result in the output
// register that drives m_tvalid. The register file sits in a synchronous memory with two
// read ports; the read is issued in the cycle the request is accepted and its
// registered data is used in the execute stage. A write by the instruction leaving
// the execute stage is forwarded to the reads issued in the same cycle, so
// back-to-back dependent instructions run at full rate. A skid-free output register
// decouples the two sides, so a new request is taken while a finished result still
// waits. Writing cfg_wr_data loads the program counter (low two bits cleared) and
// cancels any pending delayed branch; it must only be done while the unit is idle.
module risc_subset_execute_unit
	import rse_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [31:0]  cfg_wr_data,    // reset_address
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,        // instruction_word
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata, lowest bit up: next_fetch_address[31:0], writeback_valid[32],
	// writeback_index[37:33], writeback_value[69:38], store_valid[70],
	// store_address[102:71], store_value[134:103], status[136:135], zero pad.
	output logic [143:0] m_tdata
);

	// Register file memory and its per-entry valid bits. An entry that has
	// never been written reads as zero, which also keeps r0 at zero.
	logic [31:0] rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;

	// Execute stage.
	logic        vld_s1;
	logic [31:0] ins_s1;
	logic [31:0] rda_s1;
	logic [31:0] rdb_s1;
	logic        va_s1;
	logic        vb_s1;
	logic [4:0]  ra_s1;
	logic [4:0]  rb_s1;
	fwd_t        fwd_s1;

	// Architectural control state.
	logic [31:0] pc_q;
	logic        dly_pend_q;
	logic [31:0] dly_tgt_q;

	// Output register.
	logic        out_vld_q;
	result_t     out_q;

	logic        accept;
	logic        s1_fire;
	logic [4:0]  rd_a_idx;
	logic [4:0]  rd_b_idx;

	logic [31:0] op_a;
	logic [31:0] op_b;
	result_t     res;
	logic        wr_en;
	logic [4:0]  wr_idx;
	logic [31:0] wr_val;
	logic        nxt_pend;
	logic [31:0] nxt_tgt;

	assign s1_fire  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || s1_fire;
	assign accept   = s_tvalid && s_tready;

	// Port A always reads s1; port B reads the store data register for st
	// and s2 otherwise.
	assign rd_a_idx = s_tdata[20:16];
	assign rd_b_idx = (s_tdata[31:26] == OP_ST) ? s_tdata[25:21] : s_tdata[4:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_mem[wr_idx] <= wr_val;
		end
		if (accept) begin
			rda_s1 <= rf_mem[rd_a_idx];
			rdb_s1 <= rf_mem[rd_b_idx];
			ins_s1 <= s_tdata;
			ra_s1  <= rd_a_idx;
			rb_s1  <= rd_b_idx;
			va_s1  <= vld_q[rd_a_idx];
			vb_s1  <= vld_q[rd_b_idx];
			// The memory returns old data for an entry written at this edge.
			fwd_s1 <= '{en: wr_en, idx: wr_idx, val: wr_val};
		end
	end

	// Operand selection: forwarded write first, then memory if the entry is valid.
	always_comb begin
		if (fwd_s1.en && fwd_s1.idx == ra_s1) begin
			op_a = fwd_s1.val;
		end else begin
			op_a = va_s1 ? rda_s1 : 32'd0;
		end
		if (fwd_s1.en && fwd_s1.idx == rb_s1) begin
			op_b = fwd_s1.val;
		end else begin
			op_b = vb_s1 ? rdb_s1 : 32'd0;
		end
	end

	// Execute: decode, logic unit, store address, branch target and control.
	always_comb begin
		logic [5:0]  op;
		logic [4:0]  d;
		logic [15:0] imm;
		logic [7:0]  sub;
		logic [31:0] k;
		logic [31:0] lres;
		logic [31:0] target;
		logic [31:0] link_val;
		logic [31:0] seq;
		logic        logic_op;
		logic        is_br;
		logic        taken;
		logic        delayed;
		logic        link;
		status_t     stat;

		op       = ins_s1[31:26];
		d        = ins_s1[25:21];
		imm      = ins_s1[15:0];
		sub      = ins_s1[15:8];
		k        = op[0] ? {imm, 16'd0} : {16'd0, imm};
		lres     = '0;
		target   = '0;
		link_val = '0;
		seq      = pc_q + 32'd4;
		logic_op = 1'b0;
		is_br    = 1'b0;
		taken    = 1'b0;
		delayed  = 1'b0;
		link     = 1'b0;
		stat     = ST_OK;
		res      = '0;

		unique case (op) inside
			OP_ST: begin
				res.store_valid   = 1'b1;
				res.store_address = op_a + {16'd0, imm};
				res.store_value   = op_b;
			end
			OP_AND, OP_AND_U: begin
				lres     = op_a & k;
				logic_op = 1'b1;
			end
			OP_XOR, OP_XOR_U: begin
				lres     = op_a ^ k;
				logic_op = 1'b1;
			end
			OP_OR, OP_OR_U: begin
				lres     = op_a | k;
				logic_op = 1'b1;
			end
			OP_CTRL: begin
				if ((ins_s1 & LDCR_MASK) == LDCR_MATCH) begin
					stat = ST_CTRL_REG;
				end else if ((ins_s1 & STCR_MASK) == STCR_MATCH
						&& ins_s1[20:16] == ins_s1[4:0]) begin
					stat = ST_CTRL_REG;
				end else begin
					stat = ST_ILLEGAL;
				end
			end
			OP_BR, OP_BR_N, OP_BSR, OP_BSR_N: begin
				is_br    = 1'b1;
				taken    = 1'b1;
				delayed  = op[0];
				link     = op[1];
				link_val = pc_q + (op[0] ? 32'd8 : 32'd4);
				target   = pc_q + {{4{ins_s1[25]}}, ins_s1[25:0], 2'b00};
			end
			OP_BB0, OP_BB0_N, OP_BB1, OP_BB1_N: begin
				is_br   = 1'b1;
				taken   = op[1] ? op_a[d] : !op_a[d];
				delayed = op[0];
				target  = pc_q + {{14{imm[15]}}, imm, 2'b00};
			end
			OP_REGOPS: begin
				unique case (sub)
					SUB_AND: begin
						lres     = op_a & op_b;
						logic_op = 1'b1;
					end
					SUB_XOR: begin
						lres     = op_a ^ op_b;
						logic_op = 1'b1;
					end
					SUB_OR: begin
						lres     = op_a | op_b;
						logic_op = 1'b1;
					end
					SUB_JMP, SUB_JMP_N: begin
						is_br   = 1'b1;
						taken   = 1'b1;
						delayed = (sub == SUB_JMP_N);
						target  = {op_b[31:2], 2'b00};
					end
					default: stat = ST_ILLEGAL;
				endcase
			end
			default: stat = ST_ILLEGAL;
		endcase

		if (logic_op && d != 5'd0) begin
			res.writeback_valid = 1'b1;
			res.writeback_index = d;
			res.writeback_value = lres;
		end

		nxt_pend = 1'b0;
		nxt_tgt  = dly_tgt_q;
		if (dly_pend_q) begin
			// A branch in a delay slot is ignored; the pending transfer completes.
			if (is_br) begin
				stat = ST_SLOT_BRAN;
			end
			res.next_fetch_address = dly_tgt_q;
		end else if (is_br) begin
			if (link) begin
				res.writeback_valid = 1'b1;
				res.writeback_index = LINK_REG;
				res.writeback_value = link_val;
			end
			if (taken && delayed) begin
				nxt_pend               = 1'b1;
				nxt_tgt                = target;
				res.next_fetch_address = seq;
			end else if (taken) begin
				res.next_fetch_address = target;
			end else begin
				res.next_fetch_address = seq;
			end
		end else begin
			res.next_fetch_address = seq;
		end
		res.status = stat;

		wr_en  = s1_fire && res.writeback_valid;
		wr_idx = res.writeback_index;
		wr_val = res.writeback_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			out_vld_q  <= 1'b0;
			vld_q      <= '0;
			pc_q       <= '0;
			dly_pend_q <= 1'b0;
			dly_tgt_q  <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (s1_fire) begin
				vld_s1 <= 1'b0;
			end
			if (s1_fire) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (cfg_wr_en) begin
				pc_q       <= {cfg_wr_data[31:2], 2'b00};
				dly_pend_q <= 1'b0;
				dly_tgt_q  <= '0;
			end else if (s1_fire) begin
				pc_q       <= res.next_fetch_address;
				dly_pend_q <= nxt_pend;
				dly_tgt_q  <= nxt_tgt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

`ifndef ASSERT_OFF
	a_r0_never_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[0])
		else $error("register r0 marked as written");

	a_wb_not_r0: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && res.writeback_valid |-> res.writeback_index != 5'd0)
		else $error("writeback to r0");

	a_slot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && dly_pend_q |=> !dly_pend_q)
		else $error("delay slot did not complete the pending transfer");

	a_store_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |-> !(res.store_valid && res.writeback_valid))
		else $error("store and register write in one instruction");
`endif

endmodule

### tb/risc_subset_execute_unit_tb.sv
// Self-checking testbench for the RISC subset execute unit.
// Drives instruction requests, predicts every result and compares it field by field.
// Depends on rse_pkg and risc_subset_execute_unit.
`timescale 1ns / 1ps

module risc_subset_execute_unit_tb;
	import rse_pkg::*;

	// The sender and receiver hold off for at most this many cycles, so a run of
	// cycles this long without any handshake means the unit has hung.
	localparam int WATCHDOG_LIMIT = 1000;
	// Length of the forced output stall that makes the unit back up.
	localparam int HOLD_CYCLES = 64;
	// Cycles allowed after the last result before a reset vector load or the end.
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 40;
	// Encodings that the unit does not define, used for the illegal cases.
	localparam logic [5:0] OP_UNUSED = 6'h3f;
	localparam logic [7:0] SUB_UNUSED = 8'hff;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [143:0] m_tdata;

	// Architectural state as the testbench expects it to evolve.
	logic [31:0] gpr [NUM_REGS];
	logic [31:0] pc_q;
	logic [31:0] reset_vector;
	logic slot_pending;
	logic [31:0] slot_target;

	// Results still owed by the unit, oldest first.
	result_t retire_q [$];
	int mismatches = 0;
	int idle_cycles = 0;

	// Idling control: no_idle is shared by the sender and the receiver, the rest is the receiver's.
	logic no_idle = 1'b0;
	logic rx_hold_req = 1'b0;
	int rx_wait = 0;

	always #6 clk = ~clk;

	risc_subset_execute_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Instruction encoders. The immediate layout also serves st and the
	// bit-test branches, where d is the stored register or the tested bit.
	function automatic logic [31:0] enc_imm(input logic [5:0] op, input logic [4:0] rd,
			input logic [4:0] rs1, input logic [15:0] imm);
		return {op, rd, rs1, imm};
	endfunction

	function automatic logic [31:0] enc_reg(input logic [7:0] sub, input logic [4:0] rd,
			input logic [4:0] rs1, input logic [4:0] rs2);
		return {OP_REGOPS, rd, rs1, sub, 3'b000, rs2};
	endfunction

	function automatic logic [31:0] enc_br(input logic [5:0] op, input logic [25:0] disp);
		return {op, disp};
	endfunction

	function automatic logic [31:0] enc_ldcr(input logic [4:0] rd, input logic [5:0] crn);
		return {OP_CTRL, rd, 5'd0, LDCR_MATCH[15:11], crn, 5'd0};
	endfunction

	function automatic logic [31:0] enc_stcr(input logic [4:0] rs1, input logic [4:0] rs2,
			input logic [5:0] crn);
		return {OP_CTRL, 5'd0, rs1, STCR_MATCH[15:11], crn, rs2};
	endfunction

	// Retires one instruction against the expected state and returns the
	// result the unit must produce for it.
	function automatic result_t retire_instr(input logic [31:0] w);
		logic [5:0] op;
		logic [4:0] rd, rs1, rs2;
		logic [15:0] imm;
		logic [7:0] sub;
		logic [31:0] a, b, k, res, tgt, link_val, seq, nxt;
		logic is_br, taken, delayed, link, is_logic, in_slot;
		result_t r;
		op = w[31:26];
		rd = w[25:21];
		rs1 = w[20:16];
		rs2 = w[4:0];
		imm = w[15:0];
		sub = w[15:8];
		a = gpr[rs1];
		b = gpr[rs2];
		seq = pc_q + 32'd4;
		in_slot = slot_pending;
		is_br = 1'b0;
		taken = 1'b0;
		delayed = 1'b0;
		link = 1'b0;
		is_logic = 1'b0;
		res = '0;
		tgt = '0;
		link_val = '0;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_ST: begin
				r.store_valid = 1'b1;
				r.store_address = a + {16'h0, imm};
				r.store_value = gpr[rd];
			end
			OP_AND, OP_AND_U, OP_XOR, OP_XOR_U, OP_OR, OP_OR_U: begin
				// The .u forms put the immediate in the upper half.
				k = op[0] ? {imm, 16'h0} : {16'h0, imm};
				if (op == OP_AND || op == OP_AND_U) begin
					res = a & k;
				end else if (op == OP_XOR || op == OP_XOR_U) begin
					res = a ^ k;
				end else begin
					res = a | k;
				end
				is_logic = 1'b1;
			end
			OP_CTRL: begin
				if ((w & LDCR_MASK) == LDCR_MATCH) begin
					r.status = ST_CTRL_REG;
				end else if ((w & STCR_MASK) == STCR_MATCH && rs1 == rs2) begin
					r.status = ST_CTRL_REG;
				end else begin
					r.status = ST_ILLEGAL;
				end
			end
			OP_BR, OP_BR_N, OP_BSR, OP_BSR_N: begin
				is_br = 1'b1;
				taken = 1'b1;
				delayed = op[0];
				link = op[1];
				link_val = pc_q + (delayed ? 32'd8 : 32'd4);
				tgt = pc_q + {{4{w[25]}}, w[25:0], 2'b00};
			end
			OP_BB0, OP_BB0_N, OP_BB1, OP_BB1_N: begin
				is_br = 1'b1;
				taken = op[1] ? a[rd] : !a[rd];
				delayed = op[0];
				tgt = pc_q + {{14{imm[15]}}, imm, 2'b00};
			end
			OP_REGOPS: begin
				case (sub)
					SUB_AND: begin
						res = a & b;
						is_logic = 1'b1;
					end
					SUB_XOR: begin
						res = a ^ b;
						is_logic = 1'b1;
					end
					SUB_OR: begin
						res = a | b;
						is_logic = 1'b1;
					end
					SUB_JMP, SUB_JMP_N: begin
						is_br = 1'b1;
						taken = 1'b1;
						delayed = (sub == SUB_JMP_N);
						tgt = {b[31:2], 2'b00};
					end
					default: r.status = ST_ILLEGAL;
				endcase
			end
			default: r.status = ST_ILLEGAL;
		endcase

		// r0 is hard-wired to zero, so logic results aimed at it vanish.
		if (is_logic && rd != 5'd0) begin
			gpr[rd] = res;
			r.writeback_valid = 1'b1;
			r.writeback_index = rd;
			r.writeback_value = res;
		end

		if (in_slot) begin
			// A transfer inside a delay slot is ignored and flagged; the
			// pending one still completes.
			if (is_br) begin
				r.status = ST_SLOT_BRAN;
			end
			nxt = slot_target;
			slot_pending = 1'b0;
		end else if (is_br) begin
			if (link) begin
				gpr[LINK_REG] = link_val;
				r.writeback_valid = 1'b1;
				r.writeback_index = LINK_REG;
				r.writeback_value = link_val;
			end
			if (taken && delayed) begin
				slot_pending = 1'b1;
				slot_target = tgt;
				nxt = seq;
			end else if (taken) begin
				nxt = tgt;
			end else begin
				nxt = seq;
			end
		end else begin
			nxt = seq;
		end
		pc_q = nxt;
		r.next_fetch_address = nxt;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one; none in a no-idle stretch.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (no_idle) begin
			return 0;
		end else if (p < 50) begin
			return 0;
		end else if (p < 85) begin
			return $urandom_range(1, 3);
		end else if (p < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	// Low registers are favored so that instructions depend on each other.
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 3) != 0) begin
			return 5'($urandom_range(0, 7));
		end
		return 5'($urandom_range(0, 31));
	endfunction

	// Random branch offsets are near half the time, anywhere otherwise.
	function automatic logic [25:0] pick_disp();
		logic [25:0] far;
		far = 26'($urandom);
		if ($urandom_range(0, 1) != 0) begin
			return 26'($signed($urandom_range(0, 64)) - 32);
		end
		return far;
	endfunction

	// One random instruction, weighted toward legal encodings.
	function automatic logic [31:0] rand_instr();
		int pick;
		logic [4:0] rd, ra, rb;
		logic [5:0] op;
		logic [7:0] sub;
		logic [25:0] disp;
		pick = $urandom_range(0, 99);
		rd = pick_reg();
		ra = pick_reg();
		rb = pick_reg();
		disp = pick_disp();
		if (pick < 22) begin
			case ($urandom_range(0, 5))
				0: op = OP_AND;
				1: op = OP_AND_U;
				2: op = OP_XOR;
				3: op = OP_XOR_U;
				4: op = OP_OR;
				default: op = OP_OR_U;
			endcase
			return enc_imm(op, rd, ra, 16'($urandom));
		end else if (pick < 34) begin
			case ($urandom_range(0, 2))
				0: sub = SUB_AND;
				1: sub = SUB_XOR;
				default: sub = SUB_OR;
			endcase
			// Bits 7..5 are don't-care in the register form.
			return enc_reg(sub, rd, ra, rb) | ($urandom & 32'h0000_00e0);
		end else if (pick < 42) begin
			return enc_imm(OP_ST, rd, ra, 16'($urandom));
		end else if (pick < 52) begin
			return enc_br(OP_BR + 6'($urandom_range(0, 3)), disp);
		end else if (pick < 66) begin
			return enc_imm(OP_BB0 + 6'($urandom_range(0, 3)), 5'($urandom), ra, disp[15:0]);
		end else if (pick < 72) begin
			sub = ($urandom_range(0, 1) != 0) ? SUB_JMP_N : SUB_JMP;
			return enc_reg(sub, rd, ra, rb);
		end else if (pick < 78) begin
			case ($urandom_range(0, 3))
				0: return enc_ldcr(rd, 6'($urandom));
				1: return enc_stcr(ra, ra, 6'($urandom));
				2: return enc_stcr(ra, rb, 6'($urandom));
				default: return {OP_CTRL, 26'($urandom)};
			endcase
		end else if (pick < 84) begin
			return {OP_REGOPS, 26'($urandom)};
		end
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_REPORTS) begin
			$display("%0t ns: %s is %h, expected %h", $time, what, got, want);
		end
		mismatches++;
	endtask

	// Offers one request after a random gap and returns at the falling edge
	// that follows its acceptance, with tvalid still high.
	task automatic send_instr(input logic [31:0] w);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do begin
			@(posedge clk);
		end while (!s_tready);
		@(negedge clk);
	endtask

	// Stops offering requests and waits until every result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (retire_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Loads reset_address; the unit restarts there with no pending transfer.
	task automatic load_reset_vector(input logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		reset_vector = {v[31:2], 2'b00};
		pc_q = reset_vector;
		slot_pending = 1'b0;
		slot_target = '0;
	endtask

	// Receiver: random stalls, or one long hold when a test asks for it.
	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_wait = HOLD_CYCLES;
		end
		if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_tready <= 1'b1;
			rx_wait = gap_len();
		end
	end

	// Predicts each accepted request, checks each accepted result against the
	// oldest prediction, and watches for a hang.
	always @(posedge clk) begin : monitor
		result_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				retire_q.push_back(retire_instr(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (retire_q.size() == 0) begin
					report_mismatch("result with no request outstanding, next_fetch_address",
						got.next_fetch_address, 32'd0);
				end else begin
					want = retire_q.pop_front();
					if (got.next_fetch_address !== want.next_fetch_address)
						report_mismatch("next_fetch_address", got.next_fetch_address,
							want.next_fetch_address);
					if (got.writeback_valid !== want.writeback_valid)
						report_mismatch("writeback_valid", 32'(got.writeback_valid),
							32'(want.writeback_valid));
					if (got.writeback_index !== want.writeback_index)
						report_mismatch("writeback_index", 32'(got.writeback_index),
							32'(want.writeback_index));
					if (got.writeback_value !== want.writeback_value)
						report_mismatch("writeback_value", got.writeback_value,
							want.writeback_value);
					if (got.store_valid !== want.store_valid)
						report_mismatch("store_valid", 32'(got.store_valid),
							32'(want.store_valid));
					if (got.store_address !== want.store_address)
						report_mismatch("store_address", got.store_address,
							want.store_address);
					if (got.store_value !== want.store_value)
						report_mismatch("store_value", got.store_value, want.store_value);
					if (got.status !== want.status)
						report_mismatch("status", 32'(got.status), 32'(want.status));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Every logic form, st, each branch kind (br, bsr and jmp with and without a delay slot),
	// transfers inside a slot, control register accesses, illegal encodings,
	// address wrap, and a reset vector load that cancels a pending branch.
	task automatic test_directed();
		load_reset_vector(32'h0000_1000);
		send_instr(enc_imm(OP_OR_U, 5'd2, 5'd0, 16'hffff));
		send_instr(enc_imm(OP_OR, 5'd2, 5'd2, 16'hffff));
		send_instr(enc_imm(OP_XOR_U, 5'd3, 5'd2, 16'h5a5a));
		send_instr(enc_imm(OP_AND_U, 5'd4, 5'd2, 16'h8000));
		// A logic result for r0 is dropped.
		send_instr(enc_imm(OP_AND, 5'd0, 5'd2, 16'h1234));
		send_instr(enc_reg(SUB_AND, 5'd6, 5'd3, 5'd4));
		send_instr(enc_reg(SUB_XOR, 5'd7, 5'd2, 5'd3));
		send_instr(enc_reg(SUB_OR, 5'd31, 5'd4, 5'd3));
		// The store address wraps past the top of the address space.
		send_instr(enc_imm(OP_ST, 5'd31, 5'd2, 16'hffff));
		send_instr(enc_br(OP_BR_N, 26'd4));
		send_instr(enc_imm(OP_OR, 5'd8, 5'd0, 16'h0001));
		// A branch inside the slot of bsr.n is flagged and has no effect.
		send_instr(enc_br(OP_BSR_N, 26'h3ff_ffff));
		send_instr(enc_br(OP_BR, 26'd1));
		send_instr(enc_imm(OP_BB1, 5'd31, 5'd4, 16'h0002));
		// Not taken in .n form: no transfer is left pending.
		send_instr(enc_imm(OP_BB0_N, 5'd31, 5'd4, 16'h0010));
		send_instr(enc_imm(OP_BB0_N, 5'd0, 5'd0, 16'h8000));
		send_instr(enc_reg(SUB_JMP, 5'd0, 5'd0, 5'd2));
		send_instr(enc_reg(SUB_JMP_N, 5'd0, 5'd0, 5'd3));
		send_instr(enc_ldcr(5'd9, 6'h3f));
		send_instr(enc_stcr(5'd7, 5'd7, 6'h00));
		send_instr(enc_stcr(5'd7, 5'd6, 6'h15));
		send_instr(enc_reg(SUB_UNUSED, 5'd10, 5'd2, 5'd3));
		send_instr({OP_UNUSED, 26'h3ff_ffff});
		send_instr(enc_br(OP_BSR, 26'h200_0000));
		// Leave a delayed branch pending; the vector load below cancels it.
		send_instr(enc_br(OP_BR_N, 26'h1ff_ffff));
		drain();
		load_reset_vector(32'h0000_0103);
		send_instr(enc_imm(OP_XOR, 5'd11, 5'd31, 16'hffff));
		drain();
	endtask

	// Random instructions from a given reset vector, with one stretch in
	// which neither side idles.
	task automatic test_random(input logic [31:0] vector, input int count);
		load_reset_vector(vector);
		for (int i = 0; i < count; i++) begin
			no_idle = (i >= count / 2 && i < count / 2 + 50);
			send_instr(rand_instr());
		end
		no_idle = 1'b0;
		drain();
	endtask

	// The receiver stops for a long stretch while requests keep coming, so the
	// unit fills up and has to hold off its input.
	task automatic test_backpressure();
		load_reset_vector(32'h7fff_fff0);
		no_idle = 1'b1;
		rx_hold_req = 1'b1;
		for (int i = 0; i < 80; i++) begin
			send_instr(rand_instr());
		end
		no_idle = 1'b0;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		for (int i = 0; i < NUM_REGS; i++) begin
			gpr[i] = '0;
		end
		reset_vector = '0;
		pc_q = '0;
		slot_pending = 1'b0;
		slot_target = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random(32'hffff_ffff, 250);
		test_random(32'h0000_0000, 250);
		test_random($urandom, 250);
		test_backpressure();

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### sim.f
rtl/rse_pkg.sv
rtl/risc_subset_execute_unit.sv
tb/risc_subset_execute_unit_tb.sv
